// ===== src/mwrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mwrf_pkg
// Types, constants and helper functions shared by the Modbus RTU
// write-single-register framer.
// ----------------------------------------------------------------------------
package mwrf_pkg;

    localparam int unsigned FrameLen      = 8;
    localparam int unsigned HeaderLen     = 6;
    localparam int unsigned ByteIdxW      = $clog2(FrameLen);
    localparam logic [7:0]  FuncWriteReg  = 8'h06;
    localparam logic [15:0] CrcInit       = 16'hFFFF;
    localparam logic [15:0] CrcPoly       = 16'hA001;

    localparam logic [ByteIdxW-1:0] IdxSlave   = 3'd0;
    localparam logic [ByteIdxW-1:0] IdxFunc    = 3'd1;
    localparam logic [ByteIdxW-1:0] IdxAddrHi  = 3'd2;
    localparam logic [ByteIdxW-1:0] IdxAddrLo  = 3'd3;
    localparam logic [ByteIdxW-1:0] IdxValHi   = 3'd4;
    localparam logic [ByteIdxW-1:0] IdxValLo   = 3'd5;
    localparam logic [ByteIdxW-1:0] IdxCrcLo   = 3'd6;
    localparam logic [ByteIdxW-1:0] IdxCrcHi   = 3'd7;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [15:0] register_address;
        logic [15:0] register_value;
    } mwrf_in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } mwrf_out_t;

    typedef struct packed {
        mwrf_in_t    cmd;
        logic [15:0] crc;
    } mwrf_frame_t;

    function automatic logic [15:0] mwrf_crc_byte(input logic [15:0] crc_in,
                                                  input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CrcPoly;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

    function automatic logic [7:0] mwrf_frame_byte(input mwrf_frame_t fr,
                                                   input logic [ByteIdxW-1:0] idx);
        logic [7:0] b;
        case (idx)
            IdxSlave:  b = fr.cmd.slave_address;
            IdxFunc:   b = FuncWriteReg;
            IdxAddrHi: b = fr.cmd.register_address[15:8];
            IdxAddrLo: b = fr.cmd.register_address[7:0];
            IdxValHi:  b = fr.cmd.register_value[15:8];
            IdxValLo:  b = fr.cmd.register_value[7:0];
            IdxCrcLo:  b = fr.crc[7:0];
            IdxCrcHi:  b = fr.crc[15:8];
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== src/mwrf_crc_pipe.sv =====
// ----------------------------------------------------------------------------
// mwrf_crc_pipe
// Six-stage CRC pipeline: each stage folds one header byte into the
// CRC-16/MODBUS and passes the command along with its valid bit.
// ----------------------------------------------------------------------------
module mwrf_crc_pipe
    import mwrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mwrf_in_t    in_data,
    output logic        frm_valid,
    input  logic        frm_ready,
    output mwrf_frame_t frm_data
);

    logic        stage_valid_reg [HeaderLen];
    mwrf_frame_t stage_data_reg  [HeaderLen];
    logic        stage_valid_next [HeaderLen];
    mwrf_frame_t stage_data_next  [HeaderLen];
    logic        stage_src_valid [HeaderLen];
    mwrf_frame_t stage_src_data  [HeaderLen];
    logic        stage_take [HeaderLen];
    logic        stage_down_ready [HeaderLen];

    genvar k;
    generate
        for (k = 0; k < HeaderLen; k++)
        begin : g_stage
            if (k == 0)
            begin : g_first
                always_comb
                begin
                    stage_src_valid[k]     = in_valid;
                    stage_src_data[k].cmd  = in_data;
                    stage_src_data[k].crc  = CrcInit;
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    stage_src_valid[k] = stage_valid_reg[k-1];
                    stage_src_data[k]  = stage_data_reg[k-1];
                end
            end

            if (k == HeaderLen - 1)
            begin : g_last
                assign stage_down_ready[k] = frm_ready;
            end
            else
            begin : g_mid
                assign stage_down_ready[k] = stage_take[k+1];
            end

            assign stage_take[k] = !stage_valid_reg[k] || stage_down_ready[k];

            always_comb
            begin
                stage_valid_next[k]    = stage_valid_reg[k];
                stage_data_next[k]     = stage_data_reg[k];
                if (stage_take[k])
                begin
                    stage_valid_next[k]   = stage_src_valid[k];
                    stage_data_next[k].cmd = stage_src_data[k].cmd;
                    stage_data_next[k].crc = mwrf_crc_byte(
                        stage_src_data[k].crc,
                        mwrf_frame_byte(stage_src_data[k], ByteIdxW'(k)));
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    stage_valid_reg[k] <= 1'b0;
                else
                    stage_valid_reg[k] <= stage_valid_next[k];
            end

            always_ff @(posedge clk)
            begin
                stage_data_reg[k] <= stage_data_next[k];
            end
        end
    endgenerate

    assign in_ready  = stage_take[0];
    assign frm_valid = stage_valid_reg[HeaderLen-1];
    assign frm_data  = stage_data_reg[HeaderLen-1];

endmodule

// ===== src/mwrf_serializer.sv =====
// ----------------------------------------------------------------------------
// mwrf_serializer
// Holds one finished frame and sends its eight bytes through a registered
// output stage, taking the next frame as the last byte goes out.
// ----------------------------------------------------------------------------
module mwrf_serializer
    import mwrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frm_valid,
    output logic        frm_ready,
    input  mwrf_frame_t frm_data,
    output logic        out_valid,
    input  logic        out_ready,
    output mwrf_out_t   out_data
);

    mwrf_frame_t         frame_reg, frame_next;
    logic                busy_reg, busy_next;
    logic [ByteIdxW-1:0] cnt_reg, cnt_next;
    logic                ovalid_reg, ovalid_next;
    mwrf_out_t           odata_reg, odata_next;
    logic                out_free;
    logic                emit;
    logic                load;
    logic                at_last;

    assign out_free  = !ovalid_reg || out_ready;
    assign emit      = busy_reg && out_free;
    assign at_last   = (cnt_reg == IdxCrcHi);
    assign frm_ready = !busy_reg || (emit && at_last);
    assign load      = frm_valid && frm_ready;

    always_comb
    begin
        frame_next  = frame_reg;
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        if (out_ready)
            ovalid_next = 1'b0;
        if (emit)
        begin
            ovalid_next           = 1'b1;
            odata_next.frame_byte = mwrf_frame_byte(frame_reg, cnt_reg);
            odata_next.last_byte  = at_last;
            cnt_next              = cnt_reg + 1'b1;
            if (at_last)
                busy_next = 1'b0;
        end
        if (load)
        begin
            frame_next = frm_data;
            busy_next  = 1'b1;
            cnt_next   = IdxSlave;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= IdxSlave;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        odata_reg <= odata_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

endmodule

// ===== src/modbus_write_register_framer_top.sv =====
// ----------------------------------------------------------------------------
// modbus_write_register_framer_top
// Builds Modbus RTU write-single-register frames with CRC-16/MODBUS.
//
// Each input transaction carries a slave address, a register address and a
// register value. The block answers with eight output transactions, one
// frame byte each: slave address, function code 0x06, register address
// high and low, value high and low, then the CRC low and high bytes. The
// eighth byte has last_byte set.
// A six-stage pipeline folds one header byte per stage into the CRC; a
// frame buffer with a registered output stage then sends one byte per
// cycle while the receiver is ready. The first byte passes through the
// pipeline stages, the frame buffer and the output register. Commands
// queue in the pipeline while the single-byte output channel is busy.
// Reset empties the pipeline and the output stage. When the receiver
// stalls, the current byte holds, the pipeline fills and in_ready falls;
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
module modbus_write_register_framer_top
    import mwrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  mwrf_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output mwrf_out_t out_data
);

    logic        frm_valid;
    logic        frm_ready;
    mwrf_frame_t frm_data;

    mwrf_crc_pipe u_crc_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm_data  (frm_data)
    );

    mwrf_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm_data  (frm_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== tb/sv/modbus_write_register_framer_top_tb.sv =====
// ----------------------------------------------------------------------------
// modbus_write_register_framer_top_tb
// Self-checking testbench for the Modbus RTU write-single-register framer.
//
// Commands are sent over the input channel. An independent CRC-16/MODBUS
// calculation predicts the eight frame bytes that each accepted command
// should produce. Every output transaction is compared, byte and last flag,
// with the oldest predicted byte. Directed corner cases come first, then
// random commands under three idling patterns: a busy sender with a slow
// receiver, the reverse, and both sides at full rate. The sender also
// pauses once until the framer has drained completely.
// ----------------------------------------------------------------------------
module modbus_write_register_framer_top_tb
    import mwrf_pkg::*;
();

    localparam int unsigned BytesPerFrame  = 8;
    localparam logic [7:0]  FnWriteSingle  = 8'h06;
    localparam logic [15:0] Crc16Seed      = 16'hFFFF;
    localparam logic [15:0] Crc16Reflected = 16'hA001;
    localparam int unsigned StallLimit     = 5000;
    localparam int unsigned TailCycles     = 24;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    mwrf_in_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    mwrf_out_t out_data;

    mwrf_out_t   frame_bytes_due[$];
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;

    modbus_write_register_framer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [15:0] header_crc(input logic [7:0] header[6]);
        logic [15:0] crc;
        logic        feedback;
        crc = Crc16Seed;
        for (int i = 0; i < 6; i++)
        begin
            for (int b = 0; b < 8; b++)
            begin
                feedback = crc[0] ^ header[i][b];
                crc = crc >> 1;
                if (feedback)
                    crc = crc ^ Crc16Reflected;
            end
        end
        return crc;
    endfunction

    task automatic predict_frame(input mwrf_in_t cmd);
        logic [7:0]  header[6];
        logic [15:0] crc;
        mwrf_out_t   exp_byte;
        header[0] = cmd.slave_address;
        header[1] = FnWriteSingle;
        header[2] = cmd.register_address[15:8];
        header[3] = cmd.register_address[7:0];
        header[4] = cmd.register_value[15:8];
        header[5] = cmd.register_value[7:0];
        crc = header_crc(header);
        for (int i = 0; i < BytesPerFrame; i++)
        begin
            if (i < 6)
                exp_byte.frame_byte = header[i];
            else if (i == 6)
                exp_byte.frame_byte = crc[7:0];
            else
                exp_byte.frame_byte = crc[15:8];
            exp_byte.last_byte = (i == BytesPerFrame - 1);
            frame_bytes_due.push_back(exp_byte);
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        mwrf_out_t exp_byte;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_frame(in_data);
            if (out_valid && out_ready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $error("unexpected output transaction: frame_byte %02h last_byte %0b",
                           out_data.frame_byte, out_data.last_byte);
                    error_count++;
                end
                else
                begin
                    exp_byte = frame_bytes_due.pop_front();
                    if (out_data.frame_byte !== exp_byte.frame_byte)
                    begin
                        $error("frame_byte: expected %02h, actual %02h",
                               exp_byte.frame_byte, out_data.frame_byte);
                        error_count++;
                    end
                    if (out_data.last_byte !== exp_byte.last_byte)
                    begin
                        $error("last_byte: expected %0b, actual %0b",
                               exp_byte.last_byte, out_data.last_byte);
                        error_count++;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= StallLimit)
            begin
                $display("modbus_write_register_framer_top_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic send_command(input mwrf_in_t cmd);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic mwrf_in_t make_command(input logic [7:0] slave,
                                              input logic [15:0] addr,
                                              input logic [15:0] value);
        mwrf_in_t cmd;
        cmd.slave_address    = slave;
        cmd.register_address = addr;
        cmd.register_value   = value;
        return cmd;
    endfunction

    function automatic mwrf_in_t random_command();
        mwrf_in_t cmd;
        case ($urandom_range(3))
            0:
            begin
                cmd.slave_address    = 8'($urandom_range(1, 3));
                cmd.register_address = 16'($urandom_range(15));
                cmd.register_value   = 16'($urandom_range(255));
            end
            1:
            begin
                cmd.slave_address    = $urandom_range(1) ? 8'hFF : 8'h00;
                cmd.register_address =
                    16'($urandom_range(1) ? 16'hFFFF : $urandom_range(16'hFFFF));
                cmd.register_value   =
                    16'($urandom_range(1) ? 16'h0000 : $urandom_range(16'hFFFF));
            end
            default:
            begin
                cmd.slave_address    = 8'($urandom_range(8'hFF));
                cmd.register_address = 16'($urandom_range(16'hFFFF));
                cmd.register_value   = 16'($urandom_range(16'hFFFF));
            end
        endcase
        return cmd;
    endfunction

    task automatic test_directed_frames();
        send_command(make_command(8'h00, 16'h0000, 16'h0000));
        send_command(make_command(8'hFF, 16'hFFFF, 16'hFFFF));
        send_command(make_command(8'h01, 16'h0001, 16'h0003));
        send_command(make_command(8'hAA, 16'h5555, 16'hAAAA));
        send_command(make_command(8'h55, 16'hAAAA, 16'h5555));
        send_command(make_command(8'hF7, 16'h0000, 16'hFFFF));
        send_command(make_command(8'h00, 16'hFFFF, 16'h0000));
        send_command(make_command(8'h80, 16'h8000, 16'h0001));
        send_command(make_command(8'h01, 16'h0100, 16'h8000));
        send_command(make_command(8'h11, 16'h00FF, 16'hFF00));
        send_command(make_command(8'hFE, 16'hFF00, 16'h00FF));
        send_command(make_command(8'h7F, 16'h7FFF, 16'h7FFF));
    endtask

    task automatic test_random_frames(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            send_command(random_command());
    endtask

    task automatic test_pause_until_drained();
        for (int unsigned n = 0; n < 8; n++)
            send_command(random_command());
        wait_until_drained();
        for (int unsigned n = 0; n < 8; n++)
            send_command(random_command());
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct  = 13;
        rx_stall_pct = 62;
        test_directed_frames();
        test_random_frames(150);

        tx_idle_pct  = 62;
        rx_stall_pct = 13;
        test_random_frames(150);
        test_pause_until_drained();

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        test_random_frames(170);

        wait_until_drained();
        repeat (TailCycles) @(posedge clk);
        if (error_count == 0)
            $display("modbus_write_register_framer_top_tb OK");
        else
            $display("modbus_write_register_framer_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== modbus_write_register_framer_top.f =====
src/mwrf_pkg.sv
src/mwrf_crc_pipe.sv
src/mwrf_serializer.sv
src/modbus_write_register_framer_top.sv
tb/sv/modbus_write_register_framer_top_tb.sv
